// File: sv/rss_pkg.sv
// shared types for the record selection sort block
package rss_pkg;

  typedef struct packed {
    logic [15:0] record_id;
    logic [31:0] salary;
    logic        last_item;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_id;
    logic [31:0] out_salary;
    logic        out_last;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] salary;
  } rec_t;

  typedef struct packed {
    logic load;
    logic sort_init;
    logic scan_rd;
    logic swap_hi;
    logic swap_lo;
    logic emit_rd;
    logic clear;
  } rss_cmd_t;

  typedef struct packed {
    logic few;
    logic k_at_i;
    logic i_is_one;
    logic emit_end;
  } rss_sts_t;

endpackage

// File: sv/rss_ctrl.sv
// sequencing state machine for load, sort passes and emission
module rss_ctrl
  import rss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     last_item,
  input  rss_sts_t sts,
  output rss_cmd_t cmd,
  output logic     busy
);

  typedef enum logic [6:0] {
    IDLE     = 7'b0000001,
    SCAN     = 7'b0000010,
    SCAN_END = 7'b0000100,
    SWAP_HI  = 7'b0001000,
    SWAP_LO  = 7'b0010000,
    EMIT     = 7'b0100000,
    DONE     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_item) begin
            cmd.sort_init = 1'b1;
            state_nxt     = sts.few ? EMIT : SCAN;
          end
        end
      end
      SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.k_at_i) begin
          state_nxt = SCAN_END;
        end
      end
      SCAN_END: begin
        state_nxt = SWAP_HI;
      end
      SWAP_HI: begin
        cmd.swap_hi = 1'b1;
        state_nxt   = SWAP_LO;
      end
      SWAP_LO: begin
        cmd.swap_lo = 1'b1;
        state_nxt   = sts.i_is_one ? EMIT : SCAN;
      end
      EMIT: begin
        cmd.emit_rd = 1'b1;
        if (sts.emit_end) begin
          state_nxt = DONE;
        end
      end
      DONE: begin
        cmd.clear = 1'b1;
        state_nxt = IDLE;
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != IDLE);

endmodule

// File: sv/rss_datapath.sv
// record store, scan compare, swap and output registers
module rss_datapath
  import rss_pkg::*;
#(
  parameter int MAX_RECORDS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  rss_cmd_t  cmd,
  output rss_sts_t  sts,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  rec_t           mem_r [MAX_RECORDS];
  rec_t           rd_data_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic           dropped_r, dropped_nxt;
  logic [AW-1:0]  i_r, i_nxt;
  logic [AW-1:0]  k_r, k_nxt;
  logic           rd_vld_r;
  logic [AW-1:0]  rd_idx_r;
  rec_t           best_r, best_nxt;
  logic [AW-1:0]  best_idx_r, best_idx_nxt;
  rec_t           reci_r, reci_nxt;
  logic           out_vld_r;
  logic           out_last_r;

  logic           full;
  logic [AW-1:0]  top_idx;
  logic           we;
  logic [AW-1:0]  wa;
  rec_t           wd;

  assign full    = (count_r == CW'(MAX_RECORDS));
  assign top_idx = full ? AW'(MAX_RECORDS - 1) : count_r[AW-1:0];

  always_comb begin
    sts.few      = (count_r == '0);
    sts.k_at_i   = (k_r == i_r);
    sts.i_is_one = (i_r == AW'(1));
    sts.emit_end = ((CW'(k_r) + CW'(1)) == count_r);
  end

  // single write port
  always_comb begin
    we = 1'b0;
    wa = count_r[AW-1:0];
    wd = '{id: in_item.record_id, salary: in_item.salary};
    if (cmd.load && !full) begin
      we = 1'b1;
    end else if (cmd.swap_hi) begin
      we = 1'b1;
      wa = i_r;
      wd = best_r;
    end else if (cmd.swap_lo) begin
      we = 1'b1;
      wa = best_idx_r;
      wd = reci_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rd_data_r <= mem_r[k_r];
  end

  always_comb begin
    count_nxt    = count_r;
    dropped_nxt  = dropped_r;
    i_nxt        = i_r;
    k_nxt        = k_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    reci_nxt     = reci_r;
    if (cmd.load) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (cmd.clear) begin
      count_nxt   = '0;
      dropped_nxt = 1'b0;
    end
    if (cmd.sort_init) begin
      i_nxt = top_idx;
      k_nxt = '0;
    end
    if (cmd.swap_lo) begin
      i_nxt = i_r - AW'(1);
      k_nxt = '0;
    end
    if (cmd.scan_rd || cmd.emit_rd) begin
      k_nxt = k_r + AW'(1);
    end
    // running maximum, first index wins on ties
    if (rd_vld_r) begin
      if ((rd_idx_r == '0) || (rd_data_r.salary > best_r.salary)) begin
        best_nxt     = rd_data_r;
        best_idx_nxt = rd_idx_r;
      end
      if (rd_idx_r == i_r) begin
        reci_nxt = rd_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      rd_vld_r  <= cmd.scan_rd;
      out_vld_r <= cmd.emit_rd;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    rd_idx_r   <= k_r;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    reci_r     <= reci_nxt;
    out_last_r <= sts.emit_end;
  end

  assign out_valid           = out_vld_r;
  assign out_item.out_id     = rd_data_r.id;
  assign out_item.out_salary = rd_data_r.salary;
  assign out_item.out_last   = out_last_r;
  assign out_item.overflow   = dropped_r;

endmodule

// File: sv/record_selection_sort_top.sv
// top level of the record selection sort block
// Records load one per cycle while busy is low; records beyond MAX_RECORDS are
// dropped and flagged as overflow on every result of the run. The item marked
// last starts the sort: for a set of n records, each pass over positions 0..i
// reads the store one position per cycle, then makes two swap writes through
// the single write port; after the sort the n results come out on consecutive
// cycles with out_valid high, ascending by salary, and busy falls in the cycle
// after the last result. Results cannot be stalled; the receiver must take each
// one in the cycle it is shown.
module record_selection_sort_top
  import rss_pkg::*;
#(
  parameter int MAX_RECORDS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  rss_cmd_t cmd;
  rss_sts_t sts;

  rss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_item (in_item.last_item),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  rss_datapath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: sv/rss_checker.sv
// port-level checks for the record selection sort block and their binding
module rss_checker
  import rss_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside busy window");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.out_last |=> !out_valid)
    else $error("result after last item of run");

  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.out_last |=> out_valid)
    else $error("gap inside sorted run");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && !$past(out_item.out_last)
      |-> out_item.out_salary >= $past(out_item.out_salary))
    else $error("salary order broken");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_item.last_item |=> !busy && !out_valid)
    else $error("busy after plain load");

endmodule

bind record_selection_sort_top rss_checker u_rss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// File: tb/record_selection_sort_top_tb.sv
// testbench for the record selection sort block
module record_selection_sort_top_tb;
  import rss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RECORDS  = 16;
  localparam int GAP_PCT      = 13;
  localparam int TARGET_ITEMS = 450;
  localparam int SETTLE       = (MAX_RECORDS - 1) * (MAX_RECORDS + 8) / 2 + MAX_RECORDS + 16;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  rec_t        shadow_recs [MAX_RECORDS];
  int unsigned shadow_count = 0;
  logic        shadow_dropped = 1'b0;
  out_item_t   sorted_q [$];

  int gap_pct = GAP_PCT;
  int items_sent = 0;
  int sets_done = 0;
  int overflow_runs = 0;
  int results_checked = 0;
  int mismatches = 0;

  record_selection_sort_top #(.MAX_RECORDS(MAX_RECORDS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // store the record, and on the last one sort the set and queue its results
  task automatic predict_record(input in_item_t it);
    int        n;
    int        i;
    int        k;
    int        best;
    rec_t      tmp;
    out_item_t res;
    if (shadow_count < MAX_RECORDS) begin
      shadow_recs[shadow_count] = '{id: it.record_id, salary: it.salary};
      shadow_count++;
    end else begin
      shadow_dropped = 1'b1;
    end
    if (it.last_item) begin
      n = shadow_count;
      for (i = n - 1; i > 0; i--) begin
        best = 0;
        for (k = 1; k <= i; k++) begin
          if (shadow_recs[k].salary > shadow_recs[best].salary) best = k;
        end
        tmp = shadow_recs[i];
        shadow_recs[i] = shadow_recs[best];
        shadow_recs[best] = tmp;
      end
      for (k = 0; k < n; k++) begin
        res.out_id     = shadow_recs[k].id;
        res.out_salary = shadow_recs[k].salary;
        res.out_last   = (k == n - 1);
        res.overflow   = shadow_dropped;
        sorted_q.push_back(res);
      end
      sets_done++;
      if (shadow_dropped) overflow_runs++;
      shadow_count = 0;
      shadow_dropped = 1'b0;
    end
  endtask

  task automatic send_record(input logic [15:0] id, input logic [31:0] sal, input logic last);
    in_item_t it;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      in_item <= {16'($urandom), $urandom, 1'($urandom)};
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    it.record_id = id;
    it.salary    = sal;
    it.last_item = last;
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    predict_record(it);
    items_sent++;
  endtask

  // hold the sender off until every queued result has come out
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sorted_q.size() != 0);
  endtask

  function automatic logic [31:0] rand_salary(input int mode);
    logic [31:0] pool [4];
    pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0100, 32'h8000_0000};
    case (mode)
      0: return $urandom;
      1: return pool[$urandom_range(3)];
      default: return $urandom_range(7);
    endcase
  endfunction

  task automatic send_random_set(input int n);
    int mode;
    int k;
    mode = $urandom_range(3);
    for (k = 0; k < n; k++) begin
      send_record(16'($urandom_range(16'hFFFF)), rand_salary(mode == 3 ? 0 : mode),
                  k == n - 1);
    end
  endtask

  task automatic test_single_record();
    send_record(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_key_extremes();
    send_record(16'h0000, 32'hFFFF_FFFF, 1'b0);
    send_record(16'hFFFF, 32'h0000_0000, 1'b0);
    send_record(16'h1234, 32'h8000_0000, 1'b1);
  endtask

  // equal keys: selection picks the lowest index of the maximum
  task automatic test_equal_keys();
    send_record(16'h000A, 32'h0000_0500, 1'b0);
    send_record(16'h000B, 32'h0000_0500, 1'b0);
    send_record(16'h000C, 32'h0000_0500, 1'b1);
  endtask

  // a full store, then a last item that is itself dropped
  task automatic test_store_full();
    int k;
    for (k = 0; k <= MAX_RECORDS; k++) begin
      send_record(16'(16'h0100 + k), rand_salary(2), k == MAX_RECORDS);
    end
  endtask

  task automatic test_full_rate();
    gap_pct = 0;
    send_random_set(MAX_RECORDS);
    send_random_set(5);
    send_random_set(1);
    send_random_set(MAX_RECORDS + 2);
    send_random_set(8);
    gap_pct = GAP_PCT;
  endtask

  task automatic test_random_sets();
    int pick;
    int n;
    wait_drained();
    while (items_sent < TARGET_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 65)      n = $urandom_range(8, 1);
      else if (pick < 82) n = $urandom_range(MAX_RECORDS - 1, 9);
      else if (pick < 92) n = MAX_RECORDS;
      else                n = $urandom_range(MAX_RECORDS + 4, MAX_RECORDS + 1);
      send_random_set(n);
      if ($urandom_range(7) == 0) wait_drained();
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid) begin
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: id %h salary %h last %b ovf %b",
                   out_item.out_id, out_item.out_salary, out_item.out_last, out_item.overflow);
      end else begin
        exp_res = sorted_q.pop_front();
        results_checked++;
        if (out_item.out_id !== exp_res.out_id || out_item.out_salary !== exp_res.out_salary ||
            out_item.out_last !== exp_res.out_last || out_item.overflow !== exp_res.overflow) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected id %h salary %h last %b ovf %b",
                     exp_res.out_id, exp_res.out_salary, exp_res.out_last, exp_res.overflow);
            $display("          got      id %h salary %h last %b ovf %b",
                     out_item.out_id, out_item.out_salary, out_item.out_last,
                     out_item.overflow);
          end
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_single_record();
    test_key_extremes();
    test_equal_keys();
    test_store_full();
    test_full_rate();
    test_random_sets();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sorted_q.size() != 0) mismatches += sorted_q.size();
    $display("sent %0d records in %0d sets (%0d with dropped records)",
             items_sent, sets_done, overflow_runs);
    $display("checked %0d sorted results, %0d failures", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
sv/rss_pkg.sv
sv/rss_ctrl.sv
sv/rss_datapath.sv
sv/record_selection_sort_top.sv
sv/rss_checker.sv
tb/record_selection_sort_top_tb.sv
